// File: rtl/rpdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS / peak dBFS meter package
// Shared widths and fixed-point constants of the level meter.
// ----------------------------------------------------------------------------
package rpdm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int LEVEL_W  = 12;
    localparam int FRAMES_W = 11;

    // Longest block; samples past it are dropped and flagged
    localparam logic [FRAMES_W-1:0] MAX_BLOCK_FRAMES = 11'd1024;

    // 160*log10(2) and 320*log10(2) in Q16
    localparam logic [31:0] K_RMS_Q16  = 32'd3156528;
    localparam logic [31:0] K_PEAK_Q16 = 32'd6313057;

    // -120 dB floor in 1/16 dB
    localparam logic [31:0] FLOOR_LEVEL = 32'd1920;

    // Q16 offsets: full scale for mean of squares and for peak
    localparam logic [23:0] RMS_OFS_Q16  = 24'd3407872;   // 52 << 16
    localparam logic [23:0] PEAK_OFS_Q16 = 24'd2031616;   // 31 << 16

endpackage

// File: rtl/block_rms_peak_dbfs_meter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block RMS / peak level meter, dBFS output
// Accumulates sum of squares and peak magnitude per block and reports both
// levels in 1/16 dBFS when the block closes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (sample_valid / sample_stall): one signed sample per item,
//   block_end marks the last sample of a block. Output channel
//   (level_valid / level_stall): one item per block with RMS and peak level,
//   sample count and the drop flag.
//   Each accepted sample is squared on a shared bit-serial 32x32 shift-add
//   multiplier, and the input stalls until the square is added to the sum,
//   so a new sample is taken only once the last one is through (a sample
//   dropped past the block limit does not stall, unless it ends the block).
//   A block end adds the level computation: three Q16 log2 runs (normalize one
//   bit at a time, then 16 squarings) and up to two scale multiplies, all on
//   the same multiplier.
//   The result sits in an output register; the meter keeps accepting samples
//   of the next block while it waits, and only a second block end waits for
//   the register to drain when the receiver stalls.
//   Reset clears the accumulators and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module block_rms_peak_dbfs_meter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [rpdm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  block_end,
    output logic                                  level_valid,
    input  logic                                  level_stall,
    output logic signed [rpdm_pkg::LEVEL_W-1:0]   rms_level,
    output logic signed [rpdm_pkg::LEVEL_W-1:0]   peak_level,
    output logic        [rpdm_pkg::FRAMES_W-1:0]  block_frames,
    output logic                                  overflowed
);
    import rpdm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_LOG_LOAD,
        ST_LOG_NORM,
        ST_LOG_MUL,
        ST_LOG_STEP,
        ST_ATT_START,
        ST_ATT_MUL,
        ST_ATT_DONE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_SUM,
        PH_CNT,
        PH_PEAK
    } phase_t;

    state_t st_reg, st_next;
    phase_t ph_reg, ph_next;

    logic [63:0]          sum_reg, sum_next;
    logic [31:0]          peak_reg, peak_next;
    logic [FRAMES_W-1:0]  fc_reg, fc_next;
    logic                 drop_reg, drop_next;
    logic                 pend_reg, pend_next;

    // shared shift-add multiplier
    logic [63:0]          mcand_reg, mcand_next;
    logic [31:0]          mplier_reg, mplier_next;
    logic [63:0]          prod_reg, prod_next;
    logic [4:0]           mcnt_reg, mcnt_next;

    // log2 unit
    logic [63:0]          x_reg, x_next;
    logic [5:0]           e_reg, e_next;
    logic [15:0]          frac_reg, frac_next;
    logic [3:0]           it_reg, it_next;
    logic signed [23:0]   l2_reg, l2_next;

    logic signed [LEVEL_W-1:0] rms_lvl_reg, rms_lvl_next;
    logic signed [LEVEL_W-1:0] peak_lvl_reg, peak_lvl_next;

    logic                      ov_reg, ov_next;
    logic signed [LEVEL_W-1:0] orms_reg, orms_next;
    logic signed [LEVEL_W-1:0] opeak_reg, opeak_next;
    logic [FRAMES_W-1:0]       ofr_reg, ofr_next;
    logic                      odrop_reg, odrop_next;

    logic [31:0]          mag;
    logic [31:0]          pstep;
    logic [15:0]          frac_new;
    logic [30:0]          m_new;
    logic [23:0]          logv;
    logic [23:0]          neg_l2;
    logic [63:0]          rounded;
    logic [31:0]          att;
    logic signed [LEVEL_W-1:0] lvl;
    logic                 silent;
    logic                 accept;
    logic                 out_free;

    assign sample_stall = (st_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !ov_reg || !level_stall;

    assign mag      = sample[31] ? (~sample + 32'd1) : sample;
    assign pstep    = prod_reg[61:30];
    assign frac_new = {frac_reg[14:0], pstep[31]};
    assign m_new    = pstep[31] ? pstep[31:1] : pstep[30:0];
    assign logv     = {2'b00, e_reg, frac_new};
    assign neg_l2   = 24'd0 - l2_reg;
    assign rounded  = prod_reg + 64'h0000_0000_8000_0000;
    assign att      = rounded[63:32];
    assign lvl      = (att > FLOOR_LEVEL) ? -$signed(FLOOR_LEVEL[LEVEL_W-1:0])
                                          : -$signed(att[LEVEL_W-1:0]);
    assign silent   = (ph_reg == PH_PEAK) ? (peak_reg == 32'd0) : (sum_reg == 64'd0);

    // Sequencer and datapath next state
    always_comb
    begin
        st_next       = st_reg;
        ph_next       = ph_reg;
        sum_next      = sum_reg;
        peak_next     = peak_reg;
        fc_next       = fc_reg;
        drop_next     = drop_reg;
        pend_next     = pend_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        prod_next     = prod_reg;
        mcnt_next     = mcnt_reg;
        x_next        = x_reg;
        e_next        = e_reg;
        frac_next     = frac_reg;
        it_next       = it_reg;
        l2_next       = l2_reg;
        rms_lvl_next  = rms_lvl_reg;
        peak_lvl_next = peak_lvl_reg;
        ov_next       = ov_reg;
        orms_next     = orms_reg;
        opeak_next    = opeak_reg;
        ofr_next      = ofr_reg;
        odrop_next    = odrop_reg;

        // output register drains independently
        if (ov_reg && !level_stall)
        begin
            ov_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next = block_end;
                    if (fc_reg < MAX_BLOCK_FRAMES)
                    begin
                        if (mag > peak_reg)
                        begin
                            peak_next = mag;
                        end
                        fc_next     = fc_reg + 11'd1;
                        mcand_next  = {32'd0, mag};
                        mplier_next = mag;
                        prod_next   = 64'd0;
                        mcnt_next   = 5'd0;
                        st_next     = ST_SQ_MUL;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                        if (block_end)
                        begin
                            ph_next = PH_SUM;
                            st_next = ST_LOG_LOAD;
                        end
                    end
                end
            end

            ST_SQ_MUL, ST_LOG_MUL, ST_ATT_MUL:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
                mcnt_next   = mcnt_reg + 5'd1;
                if (mcnt_reg == 5'd31)
                begin
                    if (st_reg == ST_SQ_MUL)
                    begin
                        st_next = ST_SQ_ADD;
                    end
                    else if (st_reg == ST_LOG_MUL)
                    begin
                        st_next = ST_LOG_STEP;
                    end
                    else
                    begin
                        st_next = ST_ATT_DONE;
                    end
                end
            end

            ST_SQ_ADD:
            begin
                sum_next = sum_reg + {10'd0, prod_reg[63:10]};
                if (pend_reg)
                begin
                    ph_next = PH_SUM;
                    st_next = ST_LOG_LOAD;
                end
                else
                begin
                    st_next = ST_IDLE;
                end
            end

            ST_LOG_LOAD:
            begin
                case (ph_reg)
                    PH_SUM:  x_next = sum_reg;
                    PH_CNT:  x_next = {53'd0, fc_reg};
                    default: x_next = {32'd0, peak_reg};
                endcase
                e_next    = 6'd63;
                frac_next = 16'd0;
                it_next   = 4'd0;
                st_next   = ST_LOG_NORM;
            end

            // one bit of normalization per cycle
            ST_LOG_NORM:
            begin
                if (!x_reg[63] && e_reg != 6'd0)
                begin
                    x_next = {x_reg[62:0], 1'b0};
                    e_next = e_reg - 6'd1;
                end
                else
                begin
                    mcand_next  = {33'd0, x_reg[63:33]};
                    mplier_next = {1'b0, x_reg[63:33]};
                    prod_next   = 64'd0;
                    mcnt_next   = 5'd0;
                    st_next     = ST_LOG_MUL;
                end
            end

            // one fraction bit per squaring
            ST_LOG_STEP:
            begin
                frac_next = frac_new;
                it_next   = it_reg + 4'd1;
                if (it_reg == 4'd15)
                begin
                    case (ph_reg)
                        PH_SUM:
                        begin
                            l2_next = $signed(logv);
                            ph_next = PH_CNT;
                            st_next = ST_LOG_LOAD;
                        end
                        PH_CNT:
                        begin
                            l2_next = l2_reg - $signed(logv) - $signed(RMS_OFS_Q16);
                            st_next = ST_ATT_START;
                        end
                        default:
                        begin
                            l2_next = $signed(logv) - $signed(PEAK_OFS_Q16);
                            st_next = ST_ATT_START;
                        end
                    endcase
                end
                else
                begin
                    mcand_next  = {33'd0, m_new};
                    mplier_next = {1'b0, m_new};
                    prod_next   = 64'd0;
                    mcnt_next   = 5'd0;
                    st_next     = ST_LOG_MUL;
                end
            end

            ST_ATT_START:
            begin
                if (silent || !l2_reg[23])
                begin
                    if (ph_reg == PH_PEAK)
                    begin
                        peak_lvl_next = silent ? -$signed(FLOOR_LEVEL[LEVEL_W-1:0])
                                               : '0;
                        st_next = ST_FINISH;
                    end
                    else
                    begin
                        rms_lvl_next = silent ? -$signed(FLOOR_LEVEL[LEVEL_W-1:0])
                                              : '0;
                        ph_next = PH_PEAK;
                        st_next = ST_LOG_LOAD;
                    end
                end
                else
                begin
                    mcand_next  = {40'd0, neg_l2};
                    mplier_next = (ph_reg == PH_PEAK) ? K_PEAK_Q16 : K_RMS_Q16;
                    prod_next   = 64'd0;
                    mcnt_next   = 5'd0;
                    st_next     = ST_ATT_MUL;
                end
            end

            ST_ATT_DONE:
            begin
                if (ph_reg == PH_PEAK)
                begin
                    peak_lvl_next = lvl;
                    st_next = ST_FINISH;
                end
                else
                begin
                    rms_lvl_next = lvl;
                    ph_next = PH_PEAK;
                    st_next = ST_LOG_LOAD;
                end
            end

            // once the output register is free, hand the result over and start a fresh block
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    orms_next  = rms_lvl_reg;
                    opeak_next = peak_lvl_reg;
                    ofr_next   = fc_reg;
                    odrop_next = drop_reg;
                    sum_next   = 64'd0;
                    peak_next  = 32'd0;
                    fc_next    = '0;
                    drop_next  = 1'b0;
                    pend_next  = 1'b0;
                    st_next    = ST_IDLE;
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ph_reg   <= PH_SUM;
            sum_reg  <= 64'd0;
            peak_reg <= 32'd0;
            fc_reg   <= '0;
            drop_reg <= 1'b0;
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            ph_reg   <= ph_next;
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
            fc_reg   <= fc_next;
            drop_reg <= drop_next;
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        prod_reg     <= prod_next;
        mcnt_reg     <= mcnt_next;
        x_reg        <= x_next;
        e_reg        <= e_next;
        frac_reg     <= frac_next;
        it_reg       <= it_next;
        l2_reg       <= l2_next;
        rms_lvl_reg  <= rms_lvl_next;
        peak_lvl_reg <= peak_lvl_next;
        orms_reg     <= orms_next;
        opeak_reg    <= opeak_next;
        ofr_reg      <= ofr_next;
        odrop_reg    <= odrop_next;
    end

    assign level_valid  = ov_reg;
    assign rms_level    = orms_reg;
    assign peak_level   = opeak_reg;
    assign block_frames = ofr_reg;
    assign overflowed   = odrop_reg;

`ifndef NO_ASSERTIONS
    // accumulated count never passes the block limit
    a_fc_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= MAX_BLOCK_FRAMES)
        else $error("frame count past block limit");

    // a reported block always holds at least one sample
    a_frames_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid |-> (block_frames != '0 && block_frames <= MAX_BLOCK_FRAMES))
        else $error("block frame count out of range");

    // levels stay between the floor and full scale
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid |-> (rms_level <= 0 && rms_level >= -12'sd1920 &&
                         peak_level <= 0 && peak_level >= -12'sd1920))
        else $error("level out of range");

    // a drop can only be flagged in a full block
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid && overflowed |-> block_frames == MAX_BLOCK_FRAMES)
        else $error("drop flagged in short block");
`endif

endmodule

// File: tb/block_rms_peak_dbfs_meter_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter checker
// Watches both channels of the meter, predicts the RMS / peak levels of every
// closed block and compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module block_rms_peak_dbfs_meter_chk
    import rpdm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    input  logic                        sample_stall,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic                        block_end,
    input  logic                        level_valid,
    input  logic                        level_stall,
    input  logic signed [LEVEL_W-1:0]   rms_level,
    input  logic signed [LEVEL_W-1:0]   peak_level,
    input  logic        [FRAMES_W-1:0]  block_frames,
    input  logic                        overflowed,
    output int                          fail_count,
    output int                          levels_pending
);

    typedef struct packed {
        logic signed [LEVEL_W-1:0]  rms;
        logic signed [LEVEL_W-1:0]  peak;
        logic        [FRAMES_W-1:0] frames;
        logic                       ovf;
    } level_t;

    level_t      level_q[$];

    // Block accumulators of the predictor
    logic [63:0] acc_sq;
    logic [31:0] acc_peak;
    int          acc_frames;
    logic        acc_drop;

    // log2 in Q16: top bit index plus 16 fraction bits by repeated squaring
    function automatic longint log2_q16(logic [63:0] v);
        int          e;
        logic [63:0] m;
        logic [15:0] frac;
        if (v == 0)
            return 0;
        e = 63;
        while (e > 0 && !v[e])
            e--;
        m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        frac = '0;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (longint'(e) <<< 16) + longint'(frac);
    endfunction

    // Q16 log2 to 1/16 dB, rounded half away from zero, clamped to the floor
    function automatic logic signed [LEVEL_W-1:0] db_level(longint l2, logic [31:0] k);
        logic [63:0] att;
        if (l2 >= 0)
            return '0;
        att = (64'(-l2) * 64'(k) + 64'h8000_0000) >> 32;
        if (att > 64'(FLOOR_LEVEL))
            att = 64'(FLOOR_LEVEL);
        return -$signed(LEVEL_W'(att));
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Fold one accepted sample into the block; close it on block_end
    task automatic take_sample(logic [31:0] s, logic last);
        logic [31:0] mag;
        level_t      lv;
        mag = s[31] ? (~s + 32'd1) : s;
        if (acc_frames < int'(MAX_BLOCK_FRAMES))
        begin
            acc_sq += (64'(mag) * 64'(mag)) >> 10;
            if (mag > acc_peak)
                acc_peak = mag;
            acc_frames++;
        end
        else
            acc_drop = 1'b1;
        if (!last)
            return;
        if (acc_sq == 0 || acc_frames == 0)
            lv.rms = -LEVEL_W'(FLOOR_LEVEL);
        else
            lv.rms = db_level(log2_q16(acc_sq) - log2_q16(64'(acc_frames))
                              - longint'(RMS_OFS_Q16), K_RMS_Q16);
        if (acc_peak == 0)
            lv.peak = -LEVEL_W'(FLOOR_LEVEL);
        else
            lv.peak = db_level(log2_q16(64'(acc_peak)) - longint'(PEAK_OFS_Q16),
                               K_PEAK_Q16);
        lv.frames = FRAMES_W'(acc_frames);
        lv.ovf    = acc_drop;
        level_q.push_back(lv);
        acc_sq     = '0;
        acc_peak   = '0;
        acc_frames = 0;
        acc_drop   = 1'b0;
    endtask

    initial
    begin
        fail_count     = 0;
        levels_pending = 0;
        acc_sq         = '0;
        acc_peak       = '0;
        acc_frames     = 0;
        acc_drop       = 1'b0;
    end

    // Channel monitor: predict on input items, compare on output items
    always @(posedge clk)
    begin
        level_t lv;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                take_sample(sample, block_end);
            if (level_valid && !level_stall)
            begin
                if (level_q.size() == 0)
                begin
                    $display("%0t: level item with no block closed", $time);
                    fail_count++;
                end
                else
                begin
                    lv = level_q.pop_front();
                    if (rms_level !== lv.rms)
                        report("rms_level", rms_level, lv.rms);
                    if (peak_level !== lv.peak)
                        report("peak_level", peak_level, lv.peak);
                    if (block_frames !== lv.frames)
                        report("block_frames", block_frames, lv.frames);
                    if (overflowed !== lv.ovf)
                        report("overflowed", overflowed, lv.ovf);
                end
            end
        end
        levels_pending = level_q.size();
    end

endmodule

// File: tb/block_rms_peak_dbfs_meter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter testbench
// Drives directed and random sample blocks with random gaps and receiver
// stalls, including one long hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module block_rms_peak_dbfs_meter_top_tb;
    import rpdm_pkg::*;

    localparam int  HOLD_CYCLES  = 8000;
    localparam int  CYCLE_LIMIT  = 20000000;
    localparam int  RANDOM_ITEMS = 450;

    logic                       clk;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
    logic                       level_valid;
    logic                       level_stall;
    logic signed [LEVEL_W-1:0]  rms_level;
    logic signed [LEVEL_W-1:0]  peak_level;
    logic [FRAMES_W-1:0]        block_frames;
    logic                       overflowed;
    int                         fail_count;
    int                         levels_pending;
    int                         cycles;

    block_rms_peak_dbfs_meter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .block_end    (block_end),
        .level_valid  (level_valid),
        .level_stall  (level_stall),
        .rms_level    (rms_level),
        .peak_level   (peak_level),
        .block_frames (block_frames),
        .overflowed   (overflowed)
    );

    block_rms_peak_dbfs_meter_chk i_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .block_end      (block_end),
        .level_valid    (level_valid),
        .level_stall    (level_stall),
        .rms_level      (rms_level),
        .peak_level     (peak_level),
        .block_frames   (block_frames),
        .overflowed     (overflowed),
        .fail_count     (fail_count),
        .levels_pending (levels_pending)
    );

    // 20 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run-away guard
    initial
        cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Random gap before an item, with occasional stretches of none
    function automatic int draw_gap(ref int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3)
            quiet_left = 40;
        return $urandom_range(0, 3);
    endfunction

    // Level receiver: long hold-off first so the meter backs up, then random
    initial
    begin
        int quiet_left;
        int n;
        quiet_left  = 0;
        level_stall = 1'b1;
        wait (rst_n);
        for (int i = 0; i < HOLD_CYCLES; i++)
            @(posedge clk);
        forever
        begin
            n = draw_gap(quiet_left);
            if (n > 0)
            begin
                level_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            level_stall <= 1'b0;
            do
                @(posedge clk);
            while (!level_valid);
        end
    end

    int send_quiet;

    task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic last);
        int n;
        n = draw_gap(send_quiet);
        if (n > 0)
        begin
            sample_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        block_end    <= last;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    task automatic send_block(int len, logic signed [SAMPLE_W-1:0] s);
        for (int i = 0; i < len; i++)
            send_item(s, i == len - 1);
    endtask

    // Wide dynamic range: extremes, silence, and randomly scaled values
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'sh8000_0000;
            2: return 32'sh7FFF_FFFF;
            default: return $signed($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    // Stimulus and verdict
    initial
    begin
        int sent;
        int len;
        send_quiet   = 0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        block_end    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-sample blocks: silence, both extremes, small and mid-range values
        send_block(1, 32'sh0000_0000);
        send_block(1, 32'sh8000_0000);
        send_block(1, 32'sh7FFF_FFFF);
        send_block(1, 32'sh0000_0001);
        send_block(1, -32'sh1);
        send_block(1, 32'sh0000_1000);
        send_block(1, -32'sh4000_0000);
        // Mixed short blocks
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(-32'sh0000_0800, 1'b1);
        send_block(4, 32'sh0000_0000);
        send_block(3, 32'sh8000_0000);
        // Over-long block: fills to the limit, then closes on a dropped sample
        send_block(int'(MAX_BLOCK_FRAMES) + 6, -32'sh0000_0100);

        // Random blocks, mostly short, a few long
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                send_item(rand_sample(), i == len - 1);
            sent += len;
        end
        sample_valid <= 1'b0;
        @(posedge clk);

        while (levels_pending != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
